// ===== rtl/core/tun_pkg.sv =====
`default_nettype none
package tun_pkg;
  localparam int unsigned EdgeW  = 33;
  localparam int unsigned ScW    = 31;
  localparam int unsigned CrossW = 62;
  localparam int unsigned LenW   = 63;
  localparam int unsigned RootW  = 32;
  localparam int unsigned NrmW   = 16;
  localparam int unsigned QuoW   = 15;
  localparam int unsigned DivSt  = 15;
  localparam int unsigned SqSt   = 32;

  typedef struct packed {
    logic       degen;
    logic       last;
  } tun_side_t;

  function automatic logic [5:0] lead_pos(input logic [63:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

  function automatic logic [63:0] scale_to_30(input logic [63:0] m, input logic [5:0] top);
    logic [63:0] r;
    if (top >= 6'd29) r = m >> (top - 6'd29);
    else r = m << (6'd29 - top);
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/triangle_unit_normal.sv =====
`default_nettype none
// Triangle unit face normal.
// s_axis carries one triangle per item: nine signed Q16.16 coordinates in
// tdata (v0 xyz, v1 xyz, v2 xyz) and the mesh-end flag in tlast.
// m_axis returns one item per triangle: the unit normal in Q2.14 in tdata
// and the degenerate flag in tuser, tlast copied from the input.
// Edges are block scaled, crossed on six signed 32x32 multipliers, the cross
// is block scaled and squared, then a bit-per-stage square root (34 stages)
// and a restoring divider produce each component.
// Throughput is one item per cycle, back to back, unless m_axis stalls.
// The whole pipeline advances together: when m_axis stalls with a valid
// result at the output, every stage holds and s_axis_tready drops.
// Reset clears all valid bits; no item is in flight afterwards.
module triangle_unit_normal (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [287:0] s_axis_tdata,  // v0_x,v0_y,v0_z,v1_x..v2_z
  input  wire logic         s_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [47:0]       m_axis_tdata,  // normal_x, normal_y, normal_z
  output logic              m_axis_tuser,  // degenerate
  output logic              m_axis_tlast
);
  import tun_pkg::*;

  logic en;
  logic fv;
  logic signed [CrossW:0] c [3];
  tun_side_t fs, bs;

  // advance whenever the output slot is empty or being taken
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  tun_front u_front (
    .clk_i, .rst_ni, .en_i(en), .vld_i(s_axis_tvalid),
    .vtx_i(s_axis_tdata), .last_i(s_axis_tlast),
    .vld_o(fv), .c_o(c), .side_o(fs)
  );

  tun_back u_back (
    .clk_i, .rst_ni, .en_i(en), .vld_i(fv), .c_i(c), .side_i(fs),
    .vld_o(m_axis_tvalid), .nrm_o(m_axis_tdata), .side_o(bs)
  );

  assign m_axis_tuser = bs.degen;
  assign m_axis_tlast = bs.last;

`ifndef SYNTHESIS
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready) else $error("ready while stalled");
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0)) else $error("degenerate nonzero");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(m_axis_tvalid && !m_axis_tready) |-> $stable(m_axis_tdata)) else $error("output moved");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/tun_front.sv =====
`default_nettype none
module tun_front (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire logic vld_i,
  input  wire logic [32*9-1:0] vtx_i,
  input  wire logic last_i,
  output logic vld_o,
  output logic signed [tun_pkg::CrossW:0] c_o [3],
  output tun_pkg::tun_side_t side_o
);
  import tun_pkg::*;

  logic vld1_q, vld2_q;
  logic [ScW-1:0] m1_q [3], m2_q [3];
  logic [2:0] s1_q, s2_q;
  tun_side_t side1_q, side2_q;
  logic signed [EdgeW-1:0] e1 [3], e2 [3];
  logic [63:0] a1 [3], a2 [3];
  logic [5:0] t1, t2;
  logic signed [ScW:0] se1 [3], se2 [3];
  logic signed [63:0] p_q [6];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e1[k] = EdgeW'($signed(vtx_i[32*(3+k) +: 32])) - EdgeW'($signed(vtx_i[32*k +: 32]));
      e2[k] = EdgeW'($signed(vtx_i[32*(6+k) +: 32])) - EdgeW'($signed(vtx_i[32*k +: 32]));
      a1[k] = 64'(e1[k][EdgeW-1] ? -e1[k] : e1[k]);
      a2[k] = 64'(e2[k][EdgeW-1] ? -e2[k] : e2[k]);
    end
    t1 = lead_pos(a1[0] | a1[1] | a1[2]);
    t2 = lead_pos(a2[0] | a2[1] | a2[2]);
    for (int k = 0; k < 3; k++) begin
      se1[k] = s1_q[k] ? -$signed({1'b0, m1_q[k]}) : $signed({1'b0, m1_q[k]});
      se2[k] = s2_q[k] ? -$signed({1'b0, m2_q[k]}) : $signed({1'b0, m2_q[k]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        m1_q[k] <= ScW'(scale_to_30(a1[k], t1));
        m2_q[k] <= ScW'(scale_to_30(a2[k], t2));
        s1_q[k] <= e1[k][EdgeW-1];
        s2_q[k] <= e2[k][EdgeW-1];
      end
      side1_q.degen <= ((a1[0] | a1[1] | a1[2]) == '0) || ((a2[0] | a2[1] | a2[2]) == '0);
      side1_q.last  <= last_i;
      // six products, one per multiplier, then subtract
      p_q[0] <= 64'(se1[1]) * 64'(se2[2]);
      p_q[1] <= 64'(se1[2]) * 64'(se2[1]);
      p_q[2] <= 64'(se1[2]) * 64'(se2[0]);
      p_q[3] <= 64'(se1[0]) * 64'(se2[2]);
      p_q[4] <= 64'(se1[0]) * 64'(se2[1]);
      p_q[5] <= 64'(se1[1]) * 64'(se2[0]);
      side2_q <= side1_q;
    end
  end

  assign vld_o  = vld2_q;
  assign side_o = side2_q;
  always_comb begin
    for (int k = 0; k < 3; k++) c_o[k] = (CrossW+1)'(p_q[2*k] - p_q[2*k+1]);
  end
endmodule
`default_nettype wire

// ===== rtl/core/tun_back.sv =====
`default_nettype none
module tun_back (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire logic vld_i,
  input  wire logic signed [tun_pkg::CrossW:0] c_i [3],
  input  wire tun_pkg::tun_side_t side_i,
  output logic vld_o,
  output logic [3*tun_pkg::NrmW-1:0] nrm_o,
  output tun_pkg::tun_side_t side_o
);
  import tun_pkg::*;

  localparam int unsigned SN = SqSt + 2;
  localparam int unsigned DN = DivSt + 1;
  localparam int unsigned NW = RootW + 16;

  logic vc_q;
  logic [ScW-1:0] m_q [3];
  logic [2:0] s_q;
  tun_side_t sc_q;
  logic [63:0] a [3];
  logic [5:0] t;
  logic [LenW-1:0] sq_q [3];
  logic vs_q;
  logic [2:0] ss_q;
  logic [ScW-1:0] ms_q [3];
  tun_side_t sd_q;

  // square root: one result bit per stage
  logic [SN-1:0] rv_q;
  logic [LenW:0] rx_q [SN];
  logic [RootW:0] rr_q [SN];
  logic [ScW-1:0] rm_q [SN][3];
  logic [2:0] rs_q [SN];
  tun_side_t rsd_q [SN];

  // division: one quotient bit per stage, three lanes
  logic [DN-1:0] dv_q;
  logic [NW-1:0] drem_q [DN][3];
  logic [QuoW-1:0] dq_q [DN][3];
  logic [RootW:0] dd_q [DN];
  logic [2:0] ds_q [DN];
  tun_side_t dsd_q [DN];

  always_comb begin
    for (int k = 0; k < 3; k++) a[k] = 64'(c_i[k][CrossW] ? -c_i[k] : c_i[k]);
    t = lead_pos(a[0] | a[1] | a[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
      vs_q <= 1'b0;
      rv_q <= '0;
      dv_q <= '0;
    end else if (en_i) begin
      vc_q <= vld_i;
      vs_q <= vc_q;
      rv_q <= {rv_q[SN-2:0], vs_q};
      dv_q <= {dv_q[DN-2:0], rv_q[SN-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        m_q[k] <= ScW'(scale_to_30(a[k], t));
        s_q[k] <= c_i[k][CrossW];
      end
      sc_q.last  <= side_i.last;
      sc_q.degen <= side_i.degen || ((a[0] | a[1] | a[2]) == '0);
      for (int k = 0; k < 3; k++) sq_q[k] <= LenW'(m_q[k]) * LenW'(m_q[k]);
      ss_q <= s_q;
      ms_q <= m_q;
      sd_q <= sc_q;
      rx_q[0] <= {1'b0, sq_q[0]} + {1'b0, sq_q[1]} + {1'b0, sq_q[2]};
      rr_q[0] <= '0;
      rm_q[0] <= ms_q;
      rs_q[0] <= ss_q;
      rsd_q[0] <= sd_q;
      for (int i = 1; i < SN; i++) begin
        if (i <= SqSt) begin
          if ((rx_q[i-1] >> (2*(SqSt-i))) >= (LenW+1)'({rr_q[i-1], 2'b01})) begin
            rx_q[i] <= rx_q[i-1] - ((LenW+1)'({rr_q[i-1], 2'b01}) << (2*(SqSt-i)));
            rr_q[i] <= {rr_q[i-1][RootW-1:0], 1'b1};
          end else begin
            rx_q[i] <= rx_q[i-1];
            rr_q[i] <= {rr_q[i-1][RootW-1:0], 1'b0};
          end
        end else begin
          rx_q[i] <= rx_q[i-1];
          rr_q[i] <= rr_q[i-1];
        end
        rm_q[i] <= rm_q[i-1];
        rs_q[i] <= rs_q[i-1];
        rsd_q[i] <= rsd_q[i-1];
      end
      // q = floor((32768*m + r) / (2r)); m <= r keeps q at most 16384
      dd_q[0] <= {rr_q[SN-1][RootW-1:0], 1'b0};
      for (int k = 0; k < 3; k++) begin
        drem_q[0][k] <= (NW'(rm_q[SN-1][k]) << QuoW) + NW'(rr_q[SN-1]);
        dq_q[0][k] <= '0;
      end
      ds_q[0] <= rs_q[SN-1];
      dsd_q[0] <= rsd_q[SN-1];
      for (int i = 1; i < DN; i++) begin
        for (int k = 0; k < 3; k++) begin
          if (drem_q[i-1][k] >= (NW'(dd_q[i-1]) << (DivSt - i))) begin
            drem_q[i][k] <= drem_q[i-1][k] - (NW'(dd_q[i-1]) << (DivSt - i));
            dq_q[i][k] <= {dq_q[i-1][k][QuoW-2:0], 1'b1};
          end else begin
            drem_q[i][k] <= drem_q[i-1][k];
            dq_q[i][k] <= {dq_q[i-1][k][QuoW-2:0], 1'b0};
          end
        end
        dd_q[i] <= dd_q[i-1];
        ds_q[i] <= ds_q[i-1];
        dsd_q[i] <= dsd_q[i-1];
      end
    end
  end

  tun_side_t so_q;
  logic vo_q;
  logic [3*NrmW-1:0] n_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vo_q <= 1'b0;
    else if (en_i) vo_q <= dv_q[DN-1];
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      so_q <= dsd_q[DN-1];
      for (int k = 0; k < 3; k++) begin
        if (dsd_q[DN-1].degen) n_q[NrmW*k +: NrmW] <= '0;
        else if (ds_q[DN-1][k]) n_q[NrmW*k +: NrmW] <= -NrmW'(dq_q[DN-1][k]);
        else n_q[NrmW*k +: NrmW] <= NrmW'(dq_q[DN-1][k]);
      end
    end
  end
  assign vld_o  = vo_q;
  assign nrm_o  = n_q;
  assign side_o = so_q;
endmodule
`default_nettype wire

// ===== verif/tb_triangle_unit_normal.sv =====
`default_nettype none
module tb_triangle_unit_normal;

  typedef struct {
    logic signed [31:0] crd [9]; // v0 xyz, v1 xyz, v2 xyz
    logic               last;
  } tri_t;

  typedef struct {
    logic signed [15:0] nrm [3];
    logic               degen;
    logic               last;
  } normal_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [287:0] s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [47:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;

  tri_t    pending_tris[$];
  normal_t expected_normals[$];
  normal_t expected_normals_hold[$];
  logic    s_axis_tready_q = 1'b0;
  int      error_count = 0;
  int      idle_cycles = 0;

  triangle_unit_normal uut (.*);

  always #10 clk_i = ~clk_i;

  // Shift three magnitudes together until the largest lies in [2^29, 2^30).
  function automatic void scale_block(ref logic [63:0] m [3]);
    logic [63:0] top;
    top = m[0];
    if (m[1] > top) top = m[1];
    if (m[2] > top) top = m[2];
    if (top == 0) return;
    while (top >= 64'd1 << 30) begin
      for (int k = 0; k < 3; k++) m[k] = m[k] >> 1;
      top = top >> 1;
    end
    while (top < 64'd1 << 29) begin
      for (int k = 0; k < 3; k++) m[k] = m[k] << 1;
      top = top << 1;
    end
  endfunction

  function automatic logic [63:0] int_root(input logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Scale a signed vector by its block exponent, keeping signs.
  function automatic void scale_vec(ref longint v [3]);
    logic [63:0] m [3];
    for (int k = 0; k < 3; k++) m[k] = v[k] < 0 ? -v[k] : v[k];
    scale_block(m);
    for (int k = 0; k < 3; k++) v[k] = v[k] < 0 ? -longint'(m[k]) : longint'(m[k]);
  endfunction

  function automatic normal_t face_normal(input tri_t t);
    normal_t     r;
    longint      e1 [3], e2 [3], c [3];
    logic [63:0] m [3];
    logic [63:0] len2, root, q;
    for (int k = 0; k < 3; k++) begin
      e1[k] = longint'(t.crd[3+k]) - longint'(t.crd[k]);
      e2[k] = longint'(t.crd[6+k]) - longint'(t.crd[k]);
      r.nrm[k] = '0;
    end
    r.last = t.last;
    r.degen = (e1[0] == 0 && e1[1] == 0 && e1[2] == 0) ||
              (e2[0] == 0 && e2[1] == 0 && e2[2] == 0);
    if (!r.degen) begin
      scale_vec(e1);
      scale_vec(e2);
      c[0] = e1[1] * e2[2] - e1[2] * e2[1];
      c[1] = e1[2] * e2[0] - e1[0] * e2[2];
      c[2] = e1[0] * e2[1] - e1[1] * e2[0];
      if (c[0] == 0 && c[1] == 0 && c[2] == 0) begin
        r.degen = 1'b1;
      end else begin
        for (int k = 0; k < 3; k++) m[k] = c[k] < 0 ? -c[k] : c[k];
        scale_block(m);
        len2 = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        root = int_root(len2);
        for (int k = 0; k < 3; k++) begin
          q = (2 * m[k] * 64'd16384 + root) / (2 * root);
          r.nrm[k] = c[k] < 0 ? -q[15:0] : q[15:0];
        end
      end
    end
    return r;
  endfunction

  function automatic tri_t make_tri(input logic signed [31:0] a0, a1, a2, b0, b1, b2,
                                    c0, c1, c2, input logic lst);
    tri_t t;
    t.crd = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
    t.last = lst;
    return t;
  endfunction

  // Draw a coordinate: mostly full range, sometimes small or extreme.
  function automatic logic [31:0] rand_crd();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1: return 32'($signed($urandom_range(0, 64)) - 32);
      2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  function automatic tri_t rand_tri();
    tri_t t;
    for (int k = 0; k < 9; k++) t.crd[k] = rand_crd();
    t.last = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0: for (int k = 0; k < 3; k++) t.crd[3+k] = t.crd[k];     // collapse an edge
      1: for (int k = 0; k < 3; k++) t.crd[6+k] = t.crd[3+k] + t.crd[3+k] - t.crd[k];
      default: ;
    endcase
    return t;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  initial begin
    logic signed [31:0] mx, mn;
    mx = 32'sh7FFF_FFFF;
    mn = 32'sh8000_0000;
    pending_tris.push_back(make_tri(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 0));
    pending_tris.push_back(make_tri(0, 0, 0, 0, 65536, 0, 65536, 0, 0, 1));
    pending_tris.push_back(make_tri(0, 0, 0, 0, 0, 65536, 65536, 0, 0, 0));
    pending_tris.push_back(make_tri(mn, mn, mn, mx, mn, mn, mn, mx, mn, 1));
    pending_tris.push_back(make_tri(mx, mx, mx, mn, mx, mx, mx, mn, mx, 0));
    pending_tris.push_back(make_tri(mn, mx, mn, mx, mn, mx, mx, mx, mn, 0));
    pending_tris.push_back(make_tri(mn, mn, mn, mx, mx, mx, 0, 1, -1, 1));
    pending_tris.push_back(make_tri(5, 6, 7, 5, 6, 7, 1, 2, 3, 0));      // zero first edge
    pending_tris.push_back(make_tri(5, 6, 7, 1, 2, 3, 5, 6, 7, 1));      // zero edge from v0 to v2
    pending_tris.push_back(make_tri(1, 1, 1, 1, 1, 1, 1, 1, 1, 0));      // both zero
    pending_tris.push_back(make_tri(0, 0, 0, 1, 2, 3, 2, 4, 6, 0));      // parallel
    pending_tris.push_back(make_tri(0, 0, 0, 1, 2, 3, -3, -6, -9, 1));   // antiparallel
    pending_tris.push_back(make_tri(mn, mn, mn, mx, mx, mx, mx, mx, mx, 0));
    pending_tris.push_back(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 1));      // tiny edges
    pending_tris.push_back(make_tri(0, 0, 0, 1, 1, 0, mx, mx - 1, 0, 0)); // nearly parallel
    pending_tris.push_back(make_tri(0, 0, 0, -1, 0, 0, 0, 0, -1, 1));
    pending_tris.push_back(make_tri(-1, -1, -1, 0, 0, 0, 1, 2, 4, 0));
    repeat (1750) pending_tris.push_back(rand_tri());
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver: present one item at a time, with a random gap after each.
  int send_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready_q) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_tris.size() > 0) begin
          tri_t         t;
          logic [287:0] d;
          t = pending_tris.pop_front();
          for (int k = 0; k < 9; k++) d[32*k +: 32] = t.crd[k];
          s_axis_tdata <= d;
          s_axis_tlast <= t.last;
          s_axis_tvalid <= 1'b1;
          expected_normals_hold.push_back(face_normal(t));
          send_gap = $urandom_range(0, 12);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Record the handshake seen at the last rising edge for the driver.
  always @(posedge clk_i) begin
    s_axis_tready_q <= s_axis_tvalid && s_axis_tready;
    if (s_axis_tvalid && s_axis_tready)
      expected_normals.push_back(expected_normals_hold.pop_front());
  end

  // Receiver: after each accepted item, hold tready low for a random gap.
  int recv_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_normals.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        normal_t w;
        w = expected_normals.pop_front();
        for (int k = 0; k < 3; k++)
          if ($signed(m_axis_tdata[16*k +: 16]) !== w.nrm[k])
            report_mismatch($sformatf("normal[%0d]", k),
                            $signed(m_axis_tdata[16*k +: 16]), w.nrm[k]);
        if (m_axis_tuser !== w.degen) report_mismatch("degenerate", m_axis_tuser, w.degen);
        if (m_axis_tlast !== w.last) report_mismatch("last", m_axis_tlast, w.last);
      end
      recv_gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 12);
    end
  end

  // Watchdog and end of run.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("triangle_unit_normal: mismatch");
      $finish;
    end
  end

  initial begin
    wait (rst_ni);
    wait (pending_tris.size() == 0 && expected_normals_hold.size() == 0 &&
          expected_normals.size() == 0);
    repeat (200) @(posedge clk_i);
    if (error_count == 0 && expected_normals.size() == 0) begin
      $display("triangle_unit_normal: match");
    end else begin
      $display("triangle_unit_normal: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire
